// ----- sv/fraction_reducer_macros.svh -----
// Assertion macros shared by the fraction reducer checkers.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef FRACTION_REDUCER_MACROS_SVH
`define FRACTION_REDUCER_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define FR_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define FR_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/fr_pkg.sv -----
// Shared types for the fraction reducer: controller states and the
// command and status groups between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package fr_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_SCALE,
    S_DIV_N,
    S_SAVE,
    S_DIV_D,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic scale;
    logic div_step;
    logic save_n;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic special;
    logic gcd_done;
    logic div_last;
  } sts_t;

endpackage

// ----- sv/fr_datapath.sv -----
// Datapath of the fraction reducer: magnitude capture, binary GCD,
// a shared restoring divider and the signed output registers. Uses fr_pkg.
`timescale 1ns / 1ps

module fr_datapath #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  fr_pkg::cmd_t          cmd,
  output fr_pkg::sts_t          sts,
  input  logic [DATA_WIDTH-1:0] numer_in,
  input  logic [DATA_WIDTH-1:0] denom_in,
  output logic [DATA_WIDTH-1:0] numer_out,
  output logic [DATA_WIDTH-1:0] denom_out,
  output logic                  status
);
  import fr_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int KW = $clog2(DATA_WIDTH);

  logic          nneg_r, dneg_r, nzero_r, dzero_r;
  logic [W-1:0]  nmag_r, dmag_r;
  logic [W-1:0]  a_r, b_r, g_r;
  logic [KW-1:0] k_r, cnt_r;
  logic [W-1:0]  dvd_r, rem_r, qn_r;
  logic [W-1:0]  numer_out_r, denom_out_r;
  logic          status_r;

  logic [W-1:0]  nmag_in, dmag_in;
  logic [W:0]    shifted;
  logic          qbit;
  logic [W:0]    diff;

  // Magnitudes of the incoming operands; the most negative value maps to 2^(W-1).
  assign nmag_in = numer_in[W-1] ? (W'(0) - numer_in) : numer_in;
  assign dmag_in = denom_in[W-1] ? (W'(0) - denom_in) : denom_in;

  // One restoring division step: shift in the next dividend bit, try a subtract.
  assign shifted = {rem_r, dvd_r[W-1]};
  assign diff    = shifted - {1'b0, g_r};
  assign qbit    = (shifted >= {1'b0, g_r});

  // Status toward the controller.
  assign sts.special  = nzero_r | dzero_r;
  assign sts.gcd_done = (a_r == '0);
  assign sts.div_last = (cnt_r == KW'(W - 1));

  // Operand capture and binary GCD iteration.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nneg_r  <= numer_in[W-1];
      dneg_r  <= denom_in[W-1];
      nmag_r  <= nmag_in;
      dmag_r  <= dmag_in;
      nzero_r <= (nmag_in == '0);
      dzero_r <= (dmag_in == '0);
      a_r     <= nmag_in;
      b_r     <= dmag_in;
      k_r     <= '0;
    end else if (cmd.gcd_step) begin
      if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + KW'(1);
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_r >= b_r) begin
        a_r <= (a_r - b_r) >> 1;
      end else begin
        b_r <= (b_r - a_r) >> 1;
      end
    end
  end

  // Divisor, shared divider and saved numerator quotient.
  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      g_r   <= b_r << k_r;
      dvd_r <= nmag_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[W-2:0], qbit};
      rem_r <= qbit ? diff[W-1:0] : shifted[W-1:0];
      cnt_r <= cnt_r + KW'(1);
    end else if (cmd.save_n) begin
      qn_r  <= dvd_r;
      dvd_r <= dmag_r;
      rem_r <= '0;
      cnt_r <= '0;
    end
  end

  // Output registers: restore each part's sign, or zeros for the special cases.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status_r <= dzero_r;
      if (nzero_r || dzero_r) begin
        numer_out_r <= '0;
        denom_out_r <= '0;
      end else begin
        numer_out_r <= nneg_r ? (W'(0) - qn_r) : qn_r;
        denom_out_r <= dneg_r ? (W'(0) - dvd_r) : dvd_r;
      end
    end
  end

  assign numer_out = numer_out_r;
  assign denom_out = denom_out_r;
  assign status    = status_r;

endmodule

// ----- sv/fr_ctrl.sv -----
// Controller of the fraction reducer: sequences load, GCD, scaling, the two
// divisions and the result strobe. Uses fr_pkg.
`timescale 1ns / 1ps

module fr_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  output logic         out_valid,
  output fr_pkg::cmd_t cmd,
  input  fr_pkg::sts_t sts
);
  import fr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and strobe registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_GCD;
      end
      S_GCD: begin
        if (sts.special)       state_nxt = S_DONE;
        else if (sts.gcd_done) state_nxt = S_SCALE;
      end
      S_SCALE: state_nxt = S_DIV_N;
      S_DIV_N: begin
        if (sts.div_last) state_nxt = S_SAVE;
      end
      S_SAVE: state_nxt = S_DIV_D;
      S_DIV_D: begin
        if (sts.div_last) state_nxt = S_DONE;
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd           = '0;
    busy          = (state_r != S_IDLE);
    out_valid_nxt = (state_r == S_DONE);
    cmd.div_step  = (state_r inside {S_DIV_N, S_DIV_D});
    case (state_r)
      S_IDLE:  cmd.load     = start;
      S_GCD:   cmd.gcd_step = !sts.special && !sts.gcd_done;
      S_SCALE: cmd.scale    = 1'b1;
      S_SAVE:  cmd.save_n   = 1'b1;
      S_DONE:  cmd.emit     = 1'b1;
      default: cmd.emit     = 1'b0;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/fraction_reducer.sv -----
// Top level of the fraction reducer: reduces a signed fraction to lowest terms.
// Instantiates fr_ctrl and fr_datapath; uses fr_pkg.
//
//   Channel   Handshake               Ports
//   input     start high, busy low    in_numer_in, in_denom_in
//   result    out_valid, one cycle    out_numer_out, out_denom_out, out_status
//
// One transaction at a time. After the accepting edge, busy covers the binary
// GCD steps and the GCD state that sees them finish, then 2*DATA_WIDTH restoring
// division steps on the single shared divider, and the scaling, saving and
// output states. A zero numerator or denominator skips the GCD and divisions
// and keeps busy high only through the GCD and output states. The result
// strobe comes in the first idle cycle, whose closing edge may already accept
// the next transaction. Reset is synchronous and active low and returns the
// controller to idle. The receiver cannot stall; the result strobe lasts one
// cycle.
`timescale 1ns / 1ps

module fraction_reducer #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [DATA_WIDTH-1:0] in_numer_in,
  input  logic [DATA_WIDTH-1:0] in_denom_in,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] out_numer_out,
  output logic [DATA_WIDTH-1:0] out_denom_out,
  output logic                  out_status
);
  import fr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  fr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Arithmetic.
  fr_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .sts       (sts),
    .numer_in  (in_numer_in),
    .denom_in  (in_denom_in),
    .numer_out (out_numer_out),
    .denom_out (out_denom_out),
    .status    (out_status)
  );

endmodule

// ----- sv/fraction_reducer_checker.sv -----
// Port-level checks for the fraction reducer, bound to the top level.
// Depends on fraction_reducer_macros.svh.
`timescale 1ns / 1ps
`include "fraction_reducer_macros.svh"

module fraction_reducer_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [DATA_WIDTH-1:0] out_numer_out,
  input logic [DATA_WIDTH-1:0] out_denom_out,
  input logic                  out_status
);

  // An accepted transaction makes the block busy in the next cycle.
  `FR_CHECK(a_accept_busy, (start && !busy) |=> busy, "accepted transaction did not raise busy")

  // Every transaction ends with exactly one result strobe.
  `FR_CHECK(a_fell_valid, $fell(busy) |-> out_valid, "busy fell without a result")
  `FR_CHECK(a_strobe_once, out_valid |=> !out_valid, "result strobe longer than one cycle")

  // A zero denominator reports zeros in both parts.
  `FR_CHECK(a_err_zero, (out_valid && out_status) |-> (out_numer_out == '0 && out_denom_out == '0), "error result not zero")

  // Reset clears the strobe.
  `FR_CHECK_ALWAYS(a_rst_valid, !rst_n |=> !out_valid, "strobe after reset")

endmodule

bind fraction_reducer fraction_reducer_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_numer_out (out_numer_out),
  .out_denom_out (out_denom_out),
  .out_status    (out_status)
);

// ----- dv/fraction_reducer_tb.sv -----
// Self-checking testbench for fraction_reducer: drives signed fractions and
// compares every result with a behavioral reduction by the greatest common divisor.
// Depends only on the fraction_reducer RTL and its package.
`timescale 1ns / 1ps

typedef logic [31:0] word_t;

typedef struct {
  word_t numer;
  word_t denom;
  logic  status;
} fraction_t;

// Scoreboard: holds the reduced fractions still to come out of the block.
class fraction_scoreboard;
  fraction_t reduced_q[$];
  int        errors;

  function new();
    errors = 0;
  endfunction

  // Magnitude of a two's complement word, with its sign.
  function word_t magnitude(word_t v, output logic neg);
    neg = v[31];
    return neg ? -v : v;
  endfunction

  // Lowest terms of n/d; each part keeps its own sign.
  function fraction_t reduce(word_t n, word_t d);
    fraction_t res;
    logic      n_neg;
    logic      d_neg;
    word_t     n_mag;
    word_t     d_mag;
    word_t     a;
    word_t     b;
    word_t     r;
    res.numer  = '0;
    res.denom  = '0;
    res.status = 1'b0;
    n_mag = magnitude(n, n_neg);
    d_mag = magnitude(d, d_neg);
    // A zero denominator is an error; a zero numerator gives 0/0.
    if (d_mag == 0) begin
      res.status = 1'b1;
    end else if (n_mag != 0) begin
      a = n_mag;
      b = d_mag;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      res.numer = n_neg ? -(n_mag / a) : (n_mag / a);
      res.denom = d_neg ? -(d_mag / a) : (d_mag / a);
    end
    return res;
  endfunction

  // Record an accepted input transaction.
  function void note_fraction(word_t n, word_t d);
    reduced_q.push_back(reduce(n, d));
  endfunction

  // Compare one result transaction with the oldest expectation.
  function void check_result(word_t n, word_t d, logic s);
    fraction_t exp_f;
    if (reduced_q.size() == 0) begin
      $display("%0t: result with nothing expected, got %0d/%0d status %0b",
               $time, $signed(n), $signed(d), s);
      errors++;
      return;
    end
    exp_f = reduced_q.pop_front();
    if (n !== exp_f.numer) begin
      $display("%0t: numerator mismatch, expected %0d, got %0d",
               $time, $signed(exp_f.numer), $signed(n));
      errors++;
    end
    if (d !== exp_f.denom) begin
      $display("%0t: denominator mismatch, expected %0d, got %0d",
               $time, $signed(exp_f.denom), $signed(d));
      errors++;
    end
    if (s !== exp_f.status) begin
      $display("%0t: status mismatch, expected %0b, got %0b", $time, exp_f.status, s);
      errors++;
    end
  endfunction

  function int pending();
    return reduced_q.size();
  endfunction
endclass

module fraction_reducer_tb;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 550;
  localparam word_t POS_MAX = 32'h7fff_ffff;
  localparam word_t NEG_MAX = 32'h8000_0001;
  localparam word_t MOST_NEG = 32'h8000_0000;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  word_t in_numer_in = '0;
  word_t in_denom_in = '0;
  logic  out_valid;
  word_t out_numer_out;
  word_t out_denom_out;
  logic  out_status;

  fraction_scoreboard sb = new();
  int                 stall_cycles = 0;
  int                 idle_pct = 0;

  fraction_reducer #(.DATA_WIDTH(32)) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_numer_in  (in_numer_in),
    .in_denom_in  (in_denom_in),
    .out_valid    (out_valid),
    .out_numer_out(out_numer_out),
    .out_denom_out(out_denom_out),
    .out_status   (out_status)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_numer_out, out_denom_out, out_status);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one fraction from a falling edge and hold it until accepted.
  // Returns at the falling edge after the accepting edge.
  task automatic send_fraction(word_t n, word_t d);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    in_numer_in <= n;
    in_denom_in <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_fraction(n, d);
    @(negedge clk);
  endtask

  // Random value of up to w magnitude bits with a random sign.
  function automatic word_t rand_signed(int w);
    word_t v;
    v = $urandom() & ((32'h1 << w) - 1);
    return $urandom_range(1) ? -v : v;
  endfunction

  // Random word over the whole legal range; the most negative value is excluded.
  function automatic word_t rand_word();
    word_t v;
    v = $urandom();
    while (v == MOST_NEG) v = $urandom();
    return v;
  endfunction

  // Random fraction, often with a sizable common factor so reduction matters.
  task automatic send_random_fraction();
    int    kind;
    int    wg;
    word_t g;
    word_t a;
    word_t b;
    kind = $urandom_range(99);
    if (kind < 35) begin
      send_fraction(rand_word(), rand_word());
    end else if (kind < 80) begin
      wg = $urandom_range(30, 1);
      g  = ($urandom() & ((32'h1 << wg) - 1)) | 32'h1;
      a  = $urandom() & ((32'h1 << $urandom_range(31 - wg)) - 1);
      b  = ($urandom() & ((32'h1 << $urandom_range(31 - wg)) - 1)) | 32'h1;
      a  = a * g;
      b  = b * g;
      send_fraction($urandom_range(1) ? -a : a, $urandom_range(1) ? -b : b);
    end else if (kind < 92) begin
      send_fraction(rand_signed($urandom_range(8)), rand_signed($urandom_range(8)));
    end else if (kind < 96) begin
      send_fraction(32'h0, rand_word());
    end else begin
      send_fraction(rand_word(), 32'h0);
    end
  endtask

  initial begin
    int phase_pct[3];
    phase_pct[0] = 0;
    phase_pct[1] = 77;
    phase_pct[2] = 31;

    // Hold reset, then release it at a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed fractions: zeros, extremes, signs and coprime parts.
    idle_pct = 0;
    send_fraction(32'h0, 32'd5);
    send_fraction(32'h0, -32'd7);
    send_fraction(32'd5, 32'h0);
    send_fraction(-32'd9, 32'h0);
    send_fraction(32'h0, 32'h0);
    send_fraction(POS_MAX, POS_MAX);
    send_fraction(NEG_MAX, NEG_MAX);
    send_fraction(POS_MAX, NEG_MAX);
    send_fraction(NEG_MAX, 32'd1);
    send_fraction(POS_MAX, 32'd1);
    send_fraction(32'd1, POS_MAX);
    send_fraction(32'd1, NEG_MAX);
    send_fraction(-32'd1, 32'd1);
    send_fraction(32'd1, -32'd1);
    send_fraction(32'd6, 32'd4);
    send_fraction(-32'd6, -32'd4);
    send_fraction(32'd12, -32'd18);
    send_fraction(32'd7, 32'd13);
    send_fraction(32'h4000_0000, 32'h0010_0000);
    send_fraction(32'd1836311903, 32'd1134903170);
    send_fraction(32'd2147483646, 32'd1073741823);
    send_fraction(POS_MAX, 32'h0);
    send_fraction(32'h0, NEG_MAX);

    // Random fractions in three pacing phases.
    for (int p = 0; p < 3; p++) begin
      idle_pct = phase_pct[p];
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
        send_random_fraction();
      end
    end
    start <= 1'b0;

    // Drain the remaining results, then watch for strays.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
